// File: src/packet_rule_filter_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the packet rule filter
// Shared concurrent assertion forms used by packet_rule_filter_unit.
// ----------------------------------------------------------------------------
`ifndef PACKET_RULE_FILTER_UNIT_ASSERT_SVH
`define PACKET_RULE_FILTER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PRF_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PRF_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/prf_pkg.sv
// ----------------------------------------------------------------------------
// prf_pkg
// Types, sizes and codes shared by the packet rule filter modules.
// ----------------------------------------------------------------------------
package prf_pkg;

  localparam int MAX_RULES = 32;
  localparam int IDX_W     = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int CNT_W     = $clog2(MAX_RULES + 1);

  typedef enum logic [1:0] {
    CMD_CHECK  = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_SUCCESS   = 2'd0,
    ST_NO_ACTION = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_SCAN,
    S_SHIFT_UP,
    S_INS_WR,
    S_DEL_DIR,
    S_SHIFT_DN,
    S_DONE
  } fsm_state_t;

  // One rule table entry; a packet item uses the same layout.
  typedef struct packed {
    logic        accept;
    logic [15:0] dst_port_high;
    logic [15:0] dst_port_low;
    logic [15:0] src_port_high;
    logic [15:0] src_port_low;
    logic        any_protocol;
    logic [7:0]  protocol;
    logic [31:0] address;
    logic        direction;
  } rule_t;

  // Fields of a packet that a rule is compared against.
  typedef struct packed {
    logic [15:0] dport;
    logic [15:0] sport;
    logic [7:0]  protocol;
    logic [31:0] address;
    logic        direction;
  } key_t;

  // Rule table port control from the sequencer.
  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_idx;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
  } mem_req_t;

  typedef struct packed {
    logic        output_filter_on;
    logic        input_filter_on;
    logic [7:0]  rule_total;
    status_t     status;
    logic        allowed;
  } result_t;

endpackage

// File: src/prf_rule_match.sv
// ----------------------------------------------------------------------------
// prf_rule_match
// Compare unit shared by every step of the table scan.
// ----------------------------------------------------------------------------
module prf_rule_match (
  input  prf_pkg::rule_t rule,
  input  prf_pkg::key_t  key,
  output logic           match
);
  import prf_pkg::*;

  logic src_ok;
  logic dst_ok;
  logic proto_ok;

  // A range of zero to zero is a wildcard.
  assign src_ok = ((rule.src_port_low == 16'd0) && (rule.src_port_high == 16'd0)) ||
                  ((key.sport >= rule.src_port_low) &&
                   (key.sport <= rule.src_port_high));
  assign dst_ok = ((rule.dst_port_low == 16'd0) && (rule.dst_port_high == 16'd0)) ||
                  ((key.dport >= rule.dst_port_low) &&
                   (key.dport <= rule.dst_port_high));
  assign proto_ok = rule.any_protocol || (rule.protocol == key.protocol);

  assign match = rule.accept && (rule.direction == key.direction) &&
                 (rule.address == key.address) && proto_ok && src_ok && dst_ok;

endmodule

// File: src/prf_rule_store.sv
// ----------------------------------------------------------------------------
// prf_rule_store
// Rule table memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module prf_rule_store (
  input  logic              clk,
  input  prf_pkg::mem_req_t req,
  input  prf_pkg::rule_t    wr_data,
  output prf_pkg::rule_t    rd_data
);
  import prf_pkg::*;

  rule_t mem_r [MAX_RULES];
  rule_t rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem_r[req.wr_idx] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= mem_r[req.rd_idx];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: src/packet_rule_filter_unit.sv
// ----------------------------------------------------------------------------
// packet_rule_filter_unit
// Ordered IPv4 rule table with insert, delete, clear and packet check.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Payload                               Transfer when
// in_*      slave      tuser: command, tdata: rule or packet  in_tvalid & in_tready
// out_*     master     tdata: verdict, status, rule counts    out_tvalid & out_tready
//
// One item is worked on at a time; in_tready is high only while the sequencer
// is idle. A check reads the rules in order and stops at the first match (an
// empty table passes without a scan), an insert moves the entries at and above
// its place up by one and then writes the new rule, a delete moves the entries
// above the deleted rule down by one, and a clear, a refused insert or a
// refused delete goes straight to the result.
// The rule table has a single read port, which yields one entry per cycle
// to the shared compare unit or to the shift write-back.
// Reset is synchronous and active low; it empties the table at once through
// the rule counter, so no clearing pass runs. The result waits in an output
// register, and a stalled result holds the sequencer in its final state.
// ----------------------------------------------------------------------------
module packet_rule_filter_unit (
  input  logic         clk,
  input  logic         rst_n,
  // tuser: command [1:0]
  input  logic [1:0]   in_tuser,
  // tdata: position [7:0], direction [8], address [40:9], protocol [48:41],
  // any_protocol [49], src_port_low [65:50], src_port_high [81:66],
  // dst_port_low [97:82], dst_port_high [113:98], accept [114], zero [119:115]
  input  logic [119:0] in_tdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  // tdata: allowed [0], status [2:1], rule_total [10:3], input_filter_on [11],
  // output_filter_on [12], zero [15:13]
  output logic [15:0]  out_tdata,
  output logic         out_tvalid,
  input  logic         out_tready
);
  import prf_pkg::*;

  `include "packet_rule_filter_unit_assert.svh"

  fsm_state_t       state_r, state_nxt;
  cmd_t             cmd_r, cmd_nxt;
  logic [7:0]       pos_r, pos_nxt;
  rule_t            item_r, item_nxt;

  // Table occupancy; rules with input direction are rule_cnt_r - out_cnt_r.
  logic [CNT_W-1:0] rule_cnt_r, rule_cnt_nxt;
  logic [CNT_W-1:0] out_cnt_r, out_cnt_nxt;

  // Walk over the table: next read place, reads left, and the read in flight.
  logic [IDX_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [CNT_W-1:0] rd_left_r, rd_left_nxt;
  logic             rd_vld_r, rd_vld_nxt;
  logic             last_r, last_nxt;
  logic [IDX_W-1:0] wb_idx_r, wb_idx_nxt;
  logic [IDX_W-1:0] at_r, at_nxt;

  logic             allowed_r, allowed_nxt;
  status_t          status_r, status_nxt;

  logic             out_tvalid_r, out_tvalid_nxt;
  result_t          out_data_r, out_data_nxt;

  mem_req_t         mem_req;
  rule_t            wr_data;
  rule_t            rd_data;
  key_t             key;
  logic             match;

  logic [CNT_W-1:0] ins_at;
  logic             pos_beyond;

  assign key.direction = item_r.direction;
  assign key.address   = item_r.address;
  assign key.protocol  = item_r.protocol;
  assign key.sport     = item_r.src_port_low;
  assign key.dport     = item_r.dst_port_low;

  // Position 0 or past the last rule appends (insert) or is refused (delete).
  assign pos_beyond = (pos_r == 8'd0) || (pos_r > 8'(rule_cnt_r));
  assign ins_at     = pos_beyond ? rule_cnt_r : CNT_W'(pos_r - 8'd1);

  prf_rule_store u_store (
    .clk     (clk),
    .req     (mem_req),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  prf_rule_match u_match (
    .rule  (rd_data),
    .key   (key),
    .match (match)
  );

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      rule_cnt_r   <= '0;
      out_cnt_r    <= '0;
      rd_vld_r     <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      rule_cnt_r   <= rule_cnt_nxt;
      out_cnt_r    <= out_cnt_nxt;
      rd_vld_r     <= rd_vld_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // Item and walk payload.
  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    pos_r      <= pos_nxt;
    item_r     <= item_nxt;
    rd_idx_r   <= rd_idx_nxt;
    rd_left_r  <= rd_left_nxt;
    last_r     <= last_nxt;
    wb_idx_r   <= wb_idx_nxt;
    at_r       <= at_nxt;
    allowed_r  <= allowed_nxt;
    status_r   <= status_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    pos_nxt        = pos_r;
    item_nxt       = item_r;
    rule_cnt_nxt   = rule_cnt_r;
    out_cnt_nxt    = out_cnt_r;
    rd_idx_nxt     = rd_idx_r;
    rd_left_nxt    = rd_left_r;
    rd_vld_nxt     = 1'b0;
    last_nxt       = last_r;
    wb_idx_nxt     = wb_idx_r;
    at_nxt         = at_r;
    allowed_nxt    = allowed_r;
    status_nxt     = status_r;
    out_data_nxt   = out_data_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    mem_req        = '0;
    wr_data        = rd_data;
    in_tready      = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd_nxt   = cmd_t'(in_tuser);
          pos_nxt   = in_tdata[7:0];
          item_nxt  = in_tdata[114:8];
          state_nxt = S_START;
        end
      end

      S_START: begin
        allowed_nxt = 1'b0;
        status_nxt  = ST_SUCCESS;
        unique case (cmd_r)
          CMD_CHECK: begin
            if (rule_cnt_r == '0) begin
              // An empty table passes every packet.
              allowed_nxt = 1'b1;
              state_nxt   = S_DONE;
            end else begin
              rd_idx_nxt  = '0;
              rd_left_nxt = rule_cnt_r;
              state_nxt   = S_SCAN;
            end
          end
          CMD_INSERT: begin
            if (rule_cnt_r >= CNT_W'(MAX_RULES)) begin
              status_nxt = ST_FULL;
              state_nxt  = S_DONE;
            end else begin
              // Move entries at and above the insert place up by one, top first.
              at_nxt      = IDX_W'(ins_at);
              rd_left_nxt = rule_cnt_r - ins_at;
              rd_idx_nxt  = IDX_W'(rule_cnt_r - CNT_W'(1));
              state_nxt   = S_SHIFT_UP;
            end
          end
          CMD_DELETE: begin
            if ((rule_cnt_r == '0) || pos_beyond) begin
              status_nxt = ST_NO_ACTION;
              state_nxt  = S_DONE;
            end else begin
              // Fetch the doomed entry to learn its direction.
              mem_req.rd_en  = 1'b1;
              mem_req.rd_idx = IDX_W'(pos_r - 8'd1);
              rd_idx_nxt     = IDX_W'(pos_r);
              rd_left_nxt    = rule_cnt_r - CNT_W'(pos_r);
              state_nxt      = S_DEL_DIR;
            end
          end
          CMD_CLEAR: begin
            status_nxt   = (rule_cnt_r == '0) ? ST_NO_ACTION : ST_SUCCESS;
            rule_cnt_nxt = '0;
            out_cnt_nxt  = '0;
            state_nxt    = S_DONE;
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end

      S_SCAN: begin
        // Issue one read per cycle and judge the entry read the cycle before.
        if (rd_left_r != '0) begin
          mem_req.rd_en  = 1'b1;
          mem_req.rd_idx = rd_idx_r;
          rd_idx_nxt     = rd_idx_r + 1'b1;
          rd_left_nxt    = rd_left_r - 1'b1;
          rd_vld_nxt     = 1'b1;
          last_nxt       = (rd_left_r == CNT_W'(1));
        end
        if (rd_vld_r && match) begin
          allowed_nxt = 1'b1;
          rd_vld_nxt  = 1'b0;
          state_nxt   = S_DONE;
        end else if (rd_vld_r && last_r) begin
          allowed_nxt = 1'b0;
          rd_vld_nxt  = 1'b0;
          state_nxt   = S_DONE;
        end
      end

      S_SHIFT_UP: begin
        if (rd_left_r != '0) begin
          mem_req.rd_en  = 1'b1;
          mem_req.rd_idx = rd_idx_r;
          rd_idx_nxt     = rd_idx_r - 1'b1;
          rd_left_nxt    = rd_left_r - 1'b1;
          rd_vld_nxt     = 1'b1;
          wb_idx_nxt     = rd_idx_r + 1'b1;
        end
        if (rd_vld_r) begin
          mem_req.wr_en  = 1'b1;
          mem_req.wr_idx = wb_idx_r;
        end
        if ((rd_left_r == '0) && !rd_vld_r) begin
          state_nxt = S_INS_WR;
        end
      end

      S_INS_WR: begin
        mem_req.wr_en  = 1'b1;
        mem_req.wr_idx = at_r;
        wr_data        = item_r;
        rule_cnt_nxt   = rule_cnt_r + 1'b1;
        out_cnt_nxt    = out_cnt_r + CNT_W'(item_r.direction);
        state_nxt      = S_DONE;
      end

      S_DEL_DIR: begin
        out_cnt_nxt = out_cnt_r - CNT_W'(rd_data.direction);
        state_nxt   = S_SHIFT_DN;
      end

      S_SHIFT_DN: begin
        // Move entries above the deleted one down by one, bottom first.
        if (rd_left_r != '0) begin
          mem_req.rd_en  = 1'b1;
          mem_req.rd_idx = rd_idx_r;
          rd_idx_nxt     = rd_idx_r + 1'b1;
          rd_left_nxt    = rd_left_r - 1'b1;
          rd_vld_nxt     = 1'b1;
          wb_idx_nxt     = rd_idx_r - 1'b1;
        end
        if (rd_vld_r) begin
          mem_req.wr_en  = 1'b1;
          mem_req.wr_idx = wb_idx_r;
        end
        if ((rd_left_r == '0) && !rd_vld_r) begin
          rule_cnt_nxt = rule_cnt_r - 1'b1;
          state_nxt    = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_data_nxt.allowed          = allowed_r;
          out_data_nxt.status           = status_r;
          out_data_nxt.rule_total       = 8'(rule_cnt_r);
          out_data_nxt.input_filter_on  = (rule_cnt_r != out_cnt_r);
          out_data_nxt.output_filter_on = (out_cnt_r != '0);
          out_tvalid_nxt                = 1'b1;
          state_nxt                     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {3'b000, out_data_r};

  `PRF_ASSERT_IMP(a_cnt_bound, clk, rst_n, 1'b1, rule_cnt_r <= CNT_W'(MAX_RULES), "rule count exceeds table size")
  `PRF_ASSERT_IMP(a_dir_cnt, clk, rst_n, 1'b1, out_cnt_r <= rule_cnt_r, "output rule count exceeds rule count")
  `PRF_ASSERT_IMP(a_ins_room, clk, rst_n, state_r == S_INS_WR, rule_cnt_r < CNT_W'(MAX_RULES), "insert into a full table")
  `PRF_ASSERT_IMP(a_scan_rd, clk, rst_n, (state_r == S_SCAN) && mem_req.rd_en, CNT_W'(mem_req.rd_idx) < rule_cnt_r, "scan reads past the last rule")
  `PRF_ASSERT_NXT(a_result_out, clk, rst_n, (state_r == S_DONE) && !out_tvalid_r, out_tvalid_r && (state_r == S_IDLE), "finished item did not reach the output register")

endmodule
